// ===== hw/rtl/integer_to_ascii_formatter_assert.svh =====
// assertion macros used by the formatter top level
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define INTFMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// condition must never hold
`define INTFMT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define INTFMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define INTFMT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== hw/rtl/intfmt_pkg.sv =====
// types, codes and tables of the integer to ascii formatter
package intfmt_pkg;

    localparam int VALUE_WIDTH     = 32;
    localparam int DEF_QUEUE_DEPTH = 2;

    // mode codes
    localparam logic [2:0] MODE_DEC  = 3'd0;
    localparam logic [2:0] MODE_BIN  = 3'd1;
    localparam logic [2:0] MODE_QUAT = 3'd2;
    localparam logic [2:0] MODE_OCT  = 3'd3;
    localparam logic [2:0] MODE_HEX  = 3'd4;

    // digit width in bits of the hex radix
    localparam logic [2:0] HEX_BITS = 3'd4;

    localparam logic [6:0] CHAR_SEP = 7'h5f;

    localparam logic [6:0] DIGIT_CHARS [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
    };

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [2:0]             mode;
    } req_t;

    typedef struct packed {
        logic [6:0] character;
        logic       last;
    } rsp_t;

    // classified job handed from front to back
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic                   is_dec;
        logic [2:0]             bits;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

// ===== hw/rtl/intfmt_front.sv =====
// front stage: takes request beats and classifies the mode
module intfmt_front
    import intfmt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic job_valid,
    input  logic job_ready,
    output job_t job
);

    logic valid_reg, valid_next;
    job_t job_reg, job_next;
    job_t cls;

    always_comb
    begin
        cls.value  = req.value;
        cls.is_dec = (req.mode == MODE_DEC);
        if (req.mode > MODE_HEX)
        begin
            cls.bits = HEX_BITS;
        end
        else if (req.mode == MODE_DEC)
        begin
            cls.bits = HEX_BITS;
        end
        else
        begin
            cls.bits = req.mode;
        end
    end

    assign req_ready = !valid_reg || job_ready;

    always_comb
    begin
        valid_next = valid_reg;
        job_next   = job_reg;
        if (valid_reg && job_ready)
        begin
            valid_next = 1'b0;
        end
        if (req_valid && req_ready)
        begin
            valid_next = 1'b1;
            job_next   = cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    assign job_valid = valid_reg;
    assign job       = job_reg;

endmodule

// ===== hw/rtl/intfmt_fifo.sv =====
// short job queue between front and back
module intfmt_fifo
    import intfmt_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  job_t         push_job,
    output logic         pop_valid,
    input  logic         pop_ready,
    output job_t         pop_job,
    output fifo_status_t status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push, pop;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign push_ready   = !status.full;
    assign pop_valid    = !status.empty;
    assign pop_job      = mem[rd_ptr_reg];
    assign push         = push_valid && push_ready;
    assign pop          = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hw/rtl/intfmt_back.sv =====
// back stage: decimal conversion and character emission
module intfmt_back
    import intfmt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic job_valid,
    output logic job_ready,
    input  job_t job,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int W        = VALUE_WIDTH;
    localparam int PADW     = ((W + 11) / 12) * 12;
    localparam int DEC_DIG  = (W * 30103) / 100000 + 1;
    localparam int DEC_BITS = DEC_DIG * 4;
    localparam int SW       = (PADW > DEC_BITS) ? PADW : DEC_BITS;
    localparam int POSW     = $clog2(PADW + 1);
    localparam int CW       = $clog2(W);

    typedef enum logic [1:0] {S_IDLE, S_DABBLE, S_EMIT} state_t;

    state_t              state_reg, state_next;
    logic [W-1:0]        bin_reg, bin_next;
    logic [DEC_BITS-1:0] bcd_reg, bcd_next, bcd_adj;
    logic [SW-1:0]       sreg_reg, sreg_next, sreg_shift;
    logic [POSW-1:0]     pos_reg, pos_next, pos_init;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [2:0]          bits_reg, bits_next;
    logic                is_dec_reg, is_dec_next;
    logic                started_reg, started_next;
    logic                sep_done_reg, sep_done_next;
    logic                out_valid_reg, out_valid_next;
    rsp_t                out_reg, out_next;
    logic [3:0]          digit;
    logic                advance;

    // add-3 adjust ahead of each shift
    always_comb
    begin
        for (int i = 0; i < DEC_DIG; i++)
        begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ?
                                bcd_reg[i*4 +: 4] + 4'd3 : bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        case (bits_reg)
            3'd1:    digit = {3'b000, sreg_reg[SW-1]};
            3'd2:    digit = {2'b00, sreg_reg[SW-1 -: 2]};
            3'd3:    digit = {1'b0, sreg_reg[SW-1 -: 3]};
            default: digit = sreg_reg[SW-1 -: 4];
        endcase
        case (bits_reg)
            3'd1:    sreg_shift = sreg_reg << 1;
            3'd2:    sreg_shift = sreg_reg << 2;
            3'd3:    sreg_shift = sreg_reg << 3;
            default: sreg_shift = sreg_reg << 4;
        endcase
        case (job.bits)
            3'd1:    pos_init = POSW'(PADW);
            3'd2:    pos_init = POSW'(PADW / 2);
            3'd3:    pos_init = POSW'(PADW / 3);
            default: pos_init = POSW'(PADW / 4);
        endcase
    end

    assign advance   = !out_valid_reg || rsp_ready;
    assign job_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        sreg_next      = sreg_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        bits_next      = bits_reg;
        is_dec_next    = is_dec_reg;
        started_next   = started_reg;
        sep_done_next  = sep_done_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    is_dec_next   = job.is_dec;
                    bits_next     = job.bits;
                    started_next  = 1'b0;
                    sep_done_next = 1'b0;
                    if (job.is_dec)
                    begin
                        bin_next   = job.value;
                        bcd_next   = '0;
                        cnt_next   = '0;
                        state_next = S_DABBLE;
                    end
                    else
                    begin
                        sreg_next  = SW'(job.value) << (SW - PADW);
                        pos_next   = pos_init;
                        state_next = S_EMIT;
                    end
                end
            end
            S_DABBLE:
            begin
                bcd_next = {bcd_adj[DEC_BITS-2:0], bin_reg[W-1]};
                bin_next = bin_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1))
                begin
                    sreg_next  = SW'(bcd_next) << (SW - DEC_BITS);
                    pos_next   = POSW'(DEC_DIG);
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (advance)
                begin
                    if (!started_reg && digit == 4'd0 && pos_reg != POSW'(1))
                    begin
                        // leading zero
                        sreg_next = sreg_shift;
                        pos_next  = pos_reg - 1'b1;
                    end
                    else if (!is_dec_reg && started_reg && !sep_done_reg &&
                             pos_reg == POSW'(4))
                    begin
                        out_next.character = CHAR_SEP;
                        out_next.last      = 1'b0;
                        out_valid_next     = 1'b1;
                        sep_done_next      = 1'b1;
                    end
                    else
                    begin
                        out_next.character = DIGIT_CHARS[digit];
                        out_next.last      = (pos_reg == POSW'(1));
                        out_valid_next     = 1'b1;
                        started_next       = 1'b1;
                        sreg_next          = sreg_shift;
                        pos_next           = pos_reg - 1'b1;
                        if (pos_reg == POSW'(1))
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
            sep_done_reg  <= 1'b0;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            is_dec_reg    <= 1'b0;
            bits_reg      <= HEX_BITS;
            bin_reg       <= '0;
            bcd_reg       <= '0;
            sreg_reg      <= '0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            started_reg   <= started_next;
            sep_done_reg  <= sep_done_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            is_dec_reg    <= is_dec_next;
            bits_reg      <= bits_next;
            bin_reg       <= bin_next;
            bcd_reg       <= bcd_next;
            sreg_reg      <= sreg_next;
            out_reg       <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// ===== hw/rtl/integer_to_ascii_formatter.sv =====
// top level of the integer to ascii formatter
// Formats one unsigned number per request beat as ascii text, sent one
// character per response beat, most significant character first, with
// last set on the final character. Mode 0 is decimal, modes 1 to 4 are
// radix 2, 4, 8 and 16, higher codes act as hex; letters are lower case,
// zero gives a single "0", and the power-of-two radices put one underscore
// between the fourth and fifth digit from the right when there are more
// than four digits. The back end handles one number at a time.
// A power-of-two number is loaded, then the scan walks every digit
// position of the value padded to a multiple of twelve bits (36 bits for a
// 32-bit value, so 36 positions in binary, 9 in hex), leading zeros
// included, and the underscore besides. A decimal number first runs
// through a shift-and-add-3 converter, one value bit per cycle, then
// walks 10 digit positions. The conversion and the scan over digit
// positions bound the rate; a stalled response beat holds the scan.
// A two-entry job queue and a front register let requests be taken
// while the back end is still emitting.
`include "integer_to_ascii_formatter_assert.svh"

module integer_to_ascii_formatter
    import intfmt_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    // front to queue
    logic         fr_valid;
    logic         fr_ready;
    job_t         fr_job;
    // queue to back end
    logic         bk_valid;
    logic         bk_ready;
    job_t         bk_job;
    fifo_status_t fifo_stat;

    // accepts request beats and classifies the mode
    intfmt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .job_valid (fr_valid),
        .job_ready (fr_ready),
        .job       (fr_job)
    );

    // decouples the front from the long-running back end
    intfmt_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_job   (fr_job),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_job    (bk_job),
        .status     (fifo_stat)
    );

    // converts and emits characters through its output register
    intfmt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (bk_valid),
        .job_ready (bk_ready),
        .job       (bk_job),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // request side only stalls when the queue is backed up
    `INTFMT_ASSERT_IMP(a_stall_needs_full, clk, rst_n, !req_ready, fifo_stat.full, "request stalled with room in the queue")
    // queue status flags are exclusive
    `INTFMT_ASSERT_NEVER(a_fifo_flags, clk, rst_n, fifo_stat.full && fifo_stat.empty, "queue full and empty at once")
    // text never ends on the separator
    `INTFMT_ASSERT_NEVER(a_sep_not_last, clk, rst_n, rsp_valid && rsp.last && (rsp.character == CHAR_SEP), "separator flagged as last character")

endmodule

// ===== test/integer_to_ascii_formatter_tb.sv =====
// self-checking testbench for the integer to ascii formatter
module integer_to_ascii_formatter_tb;
    import intfmt_pkg::*;

    // grouping and radix of the text format
    localparam int GROUP_DIGITS   = 4;
    localparam int DEC_RADIX      = 10;
    // quiet cycles with no beat on either channel before the run is abandoned
    localparam int WATCHDOG_LIMIT = 4000;
    // drain time after the last expected character, above the decimal latency
    localparam int TAIL_CYCLES    = 64;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_ITEMS   = 380;

    // expected text of accepted numbers, checked beat by beat
    class text_scoreboard;
        rsp_t pending[$];
        int   mismatches;

        function new();
            mismatches = 0;
        endfunction

        // format one accepted number and queue its characters, most significant first
        function void note_request(req_t item);
            logic [6:0]             digits[$];
            logic [VALUE_WIDTH-1:0] num;
            logic [VALUE_WIDTH-1:0] dmask;
            logic [2:0]             bits;
            int                     count;
            rsp_t                   beat;
            num = item.value;
            if (item.mode == MODE_DEC)
            begin
                do
                begin
                    digits.push_front(DIGIT_CHARS[4'(num % DEC_RADIX)]);
                    num = num / DEC_RADIX;
                end
                while (num != 0);
            end
            else
            begin
                // codes above hex saturate to hex
                bits  = (item.mode > MODE_HEX) ? HEX_BITS : item.mode;
                dmask = (VALUE_WIDTH'(1) << bits) - 1'b1;
                count = 0;
                do
                begin
                    if (count == GROUP_DIGITS)
                        digits.push_front(CHAR_SEP);
                    count++;
                    digits.push_front(DIGIT_CHARS[4'(num & dmask)]);
                    num = num >> bits;
                end
                while (num != 0);
            end
            foreach (digits[k])
            begin
                beat.character = digits[k];
                beat.last      = (k == digits.size() - 1);
                pending.push_back(beat);
            end
        endfunction

        function void check_char(rsp_t got);
            rsp_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected beat: char %h last %b with nothing pending",
                             got.character, got.last);
                return;
            end
            want = pending.pop_front();
            if (got.character !== want.character || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: expected char %h last %b, got char %h last %b",
                             want.character, want.last, got.character, got.last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    // idle chances in percent, changed between phases
    int req_idle_pct;
    int rsp_idle_pct;
    int quiet_cycles;

    text_scoreboard numbers = new();

    integer_to_ascii_formatter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // both channels are sampled at the rising edge, where the stimulus is stable
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                numbers.note_request(req);
            if (rsp_valid && rsp_ready)
                numbers.check_char(rsp);
        end
    end

    // receiver: ready changes only at the falling edge, one assignment per edge
    initial
    begin
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    // watchdog: a stuck handshake on both sides ends the run
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("integer_to_ascii_formatter_tb: done, errors");
        $finish;
    end

    // offer one number, idling first at random, and hold it until the beat is taken
    task automatic send_number(input logic [VALUE_WIDTH-1:0] value, input logic [2:0] mode);
        req_t item;
        item.value = value;
        item.mode  = mode;
        @(negedge clk);
        // each idle cycle drops valid once, so no edge sees two assignments
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // random numbers: shortened values so every text length shows up, in
    // equal shares with full-width values, tiny ones and single set bits
    task automatic send_random(input int count);
        logic [VALUE_WIDTH-1:0] value;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(3))
                0: value = $urandom;
                1: value = $urandom >> $urandom_range(VALUE_WIDTH - 1);
                2: value = $urandom_range(DEC_RADIX * 2);
                default: value = VALUE_WIDTH'(1) << $urandom_range(VALUE_WIDTH - 1);
            endcase
            send_number(value, 3'($urandom_range(7)));
        end
    endtask

    initial
    begin
        int guard;
        req_valid    = 1'b0;
        req          = '0;
        rst_n        = 1'b0;
        req_idle_pct = 10;
        rsp_idle_pct = 67;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero and all-ones in every mode code, saturating codes included
        for (int m = 0; m < 8; m++)
            send_number('0, 3'(m));
        for (int m = 0; m < 8; m++)
            send_number('1, 3'(m));

        // underscore threshold: four digits against five in each radix
        send_number(32'h0000_000f, MODE_BIN);
        send_number(32'h0000_0010, MODE_BIN);
        send_number(32'h0000_00ff, MODE_QUAT);
        send_number(32'h0000_0100, MODE_QUAT);
        send_number(32'o7777,      MODE_OCT);
        send_number(32'o10000,     MODE_OCT);
        send_number(32'h0000_ffff, MODE_HEX);
        send_number(32'h0001_0000, MODE_HEX);
        // decimal carries into a new digit
        send_number(32'd9,         MODE_DEC);
        send_number(32'd10,        MODE_DEC);

        // sender mostly busy, receiver mostly stalling
        send_random(RANDOM_ITEMS / 3);
        // then the other way round
        req_idle_pct = 67;
        rsp_idle_pct = 10;
        send_random(RANDOM_ITEMS / 3);
        // full rate on both sides
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        send_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

        @(negedge clk);
        req_valid <= 1'b0;

        // drain the outstanding text, then give any stray beats time to show
        guard = 0;
        while (numbers.pending.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (numbers.pending.size() != 0)
            $display("%0d expected characters never arrived", numbers.pending.size());

        if (numbers.mismatches == 0 && numbers.pending.size() == 0)
            $display("integer_to_ascii_formatter_tb: done, clean");
        else
            $display("integer_to_ascii_formatter_tb: done, errors");
        $finish;
    end

endmodule
